FILE: hw/rtl/midi_clock_tempo_pulse_generator_macros.svh
// assertion macros for the midi clock tempo pulse generator
`ifndef MIDI_CLOCK_TEMPO_PULSE_GENERATOR_MACROS_SVH
`define MIDI_CLOCK_TEMPO_PULSE_GENERATOR_MACROS_SVH

// property that must hold at every edge out of reset
`define MCTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define MCTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/mctp_pkg.sv
// shared types and constants for the midi clock tempo pulse generator
`default_nettype none

package mctp_pkg;

  localparam int unsigned TICKS_PER_BEAT_DEF = 24;

  localparam logic [31:0] SILENCE_RESET   = 32'd500000;
  localparam logic [31:0] BEAT_RESET      = 32'd500000;
  localparam logic [7:0]  PULSE_TICKS_RST = 8'd24;
  localparam logic [31:0] GAP_MIN_RESET   = 32'hFFFF_FFFF;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CFG_IDX_W   = 8;

  typedef enum logic [2:0] {
    MODE_TICK       = 3'd0,
    MODE_START      = 3'd1,
    MODE_CONTINUE   = 3'd2,
    MODE_STOP       = 3'd3,
    MODE_IDLE_CHECK = 3'd4,
    MODE_SET_DIV    = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLOCK_SILENCE = 8'd0,
    CFG_DEFAULT_BEAT  = 8'd1
  } cfg_idx_t;

  typedef struct packed {
    logic        free_run;
    logic [31:0] since_last_pulse_us;
    logic [31:0] beat_interval_us;
    logic [15:0] ticks_counted;
    logic [31:0] min_gap_us;
    logic [31:0] max_gap_us;
  } result_t;

  typedef struct packed {
    logic proc_en;
    logic hold_active;
    logic param_change;
  } core_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mctp_ifs.sv
// valid/ready channel interfaces: event input, pulse output, register writes
`default_nettype none

interface mctp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] time_us;
  logic [7:0]  new_ticks_per_pulse;

  modport source(output valid, mode, time_us, new_ticks_per_pulse, input ready);
  modport sink(input valid, mode, time_us, new_ticks_per_pulse, output ready);
endinterface

interface mctp_out_if;
  logic        valid;
  logic        ready;
  logic        free_run;
  logic [31:0] since_last_pulse_us;
  logic [31:0] beat_interval_us;
  logic [15:0] ticks_counted;
  logic [31:0] min_gap_us;
  logic [31:0] max_gap_us;

  modport source(output valid, free_run, since_last_pulse_us, beat_interval_us,
                 ticks_counted, min_gap_us, max_gap_us, input ready);
  modport sink(input valid, free_run, since_last_pulse_us, beat_interval_us,
               ticks_counted, min_gap_us, max_gap_us, output ready);
endinterface

interface mctp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mctp_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mctp_interval.sv
// free-run pulse interval: beat length per tick times ticks per pulse, two stages
`default_nettype none

module mctp_interval #(
  parameter int unsigned TICKS_PER_BEAT = mctp_pkg::TICKS_PER_BEAT_DEF
) (
  input  wire logic        clk,
  input  wire logic [31:0] beat_length_i,
  input  wire logic [7:0]  pulse_ticks_i,
  output logic      [31:0] interval_o
);

  localparam int unsigned DIV_SHIFT = $clog2(TICKS_PER_BEAT);
  // ceil(2^(32+shift) / ticks) gives the exact quotient for every 32-bit beat length
  localparam logic [32:0] RECIP =
    33'(((65'd1 << (32 + DIV_SHIFT)) + 65'(TICKS_PER_BEAT) - 65'd1) / 65'(TICKS_PER_BEAT));

  logic [31:0] beat_div_r;
  logic [31:0] beat_div_nxt;
  logic [64:0] scaled;
  logic [39:0] product;
  logic [31:0] interval_r;

  // divide by ticks per beat as a reciprocal multiply and shift
  assign scaled       = {33'd0, beat_length_i} * {32'd0, RECIP};
  assign beat_div_nxt = 32'(scaled >> (32 + DIV_SHIFT));
  assign product      = {8'd0, beat_div_r} * {32'd0, pulse_ticks_i};

  always_ff @(posedge clk) begin
    beat_div_r <= beat_div_nxt;
    interval_r <= product[31:0];
  end

  assign interval_o = interval_r;

endmodule

`default_nettype wire

FILE: hw/rtl/mctp_out_queue.sv
// small result queue between the event core and the pulse output channel
`default_nettype none

module mctp_out_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push_i,
  input  wire mctp_pkg::result_t             data_i,
  output logic      [mctp_pkg::QCNT_W-1:0]   count_o,
  mctp_out_if.source                         out_chan
);

  mctp_pkg::result_t                 entry_r [mctp_pkg::QUEUE_DEPTH];
  logic [mctp_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [mctp_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [mctp_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                              pop;
  mctp_pkg::result_t                 head;

  assign pop  = out_chan.valid && out_chan.ready;
  assign head = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_i ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push_i && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      entry_r[wr_ptr_r] <= data_i;
    end
  end

  assign count_o                      = count_r;
  assign out_chan.valid               = (count_r != '0);
  assign out_chan.free_run            = head.free_run;
  assign out_chan.since_last_pulse_us = head.since_last_pulse_us;
  assign out_chan.beat_interval_us    = head.beat_interval_us;
  assign out_chan.ticks_counted       = head.ticks_counted;
  assign out_chan.min_gap_us          = head.min_gap_us;
  assign out_chan.max_gap_us          = head.max_gap_us;

endmodule

`default_nettype wire

FILE: hw/rtl/mctp_core.sv
// event register, tempo state and pulse decision for one event per cycle unless the input stalls
`default_nettype none

module mctp_core #(
  parameter int unsigned TICKS_PER_BEAT = mctp_pkg::TICKS_PER_BEAT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mctp_in_if.sink                          in_chan,
  mctp_cfg_if.sink                         cfg_chan,
  input  wire logic [31:0]                 interval_i,
  input  wire logic [mctp_pkg::QCNT_W-1:0] q_count_i,
  output logic      [31:0]                 beat_length_o,
  output logic      [7:0]                  pulse_ticks_o,
  output logic                             res_push_o,
  output mctp_pkg::result_t                res_o,
  output mctp_pkg::core_status_t           status_o
);

  localparam logic [7:0] TPB = 8'(TICKS_PER_BEAT);

  // event register
  logic        item_valid_r, item_valid_nxt;
  logic [2:0]  item_mode_r;
  logic [31:0] item_time_r;
  logic [7:0]  item_ntp_r;

  logic [31:0] silence_r, silence_nxt;
  logic [1:0]  hold_r, hold_nxt;

  logic [7:0]  pulse_ticks_r, pulse_ticks_nxt;
  logic [7:0]  tsp_r, tsp_nxt;
  logic [7:0]  tsb_r, tsb_nxt;
  logic [31:0] beat_length_r, beat_length_nxt;
  logic [31:0] last_beat_r, last_beat_nxt;
  logic [31:0] last_clock_r, last_clock_nxt;
  logic [31:0] last_tick_r, last_tick_nxt;
  logic [31:0] last_pulse_r, last_pulse_nxt;
  logic [15:0] tally_r, tally_nxt;
  logic [31:0] gap_min_r, gap_min_nxt;
  logic [31:0] gap_max_r, gap_max_nxt;
  logic        running_r, running_nxt;

  logic        proc_en;
  logic        accept;
  logic [mctp_pkg::QCNT_W:0] occupancy;
  logic [31:0] now;
  logic [31:0] gap;
  logic [31:0] since;
  logic [31:0] gmin, gmax, blen;
  logic [15:0] tally_inc;
  logic [7:0]  tsb_inc, tsp_inc;
  logic        param_change;
  logic        res_push;
  mctp_pkg::result_t res;

  assign proc_en   = item_valid_r && (hold_r == '0);
  // every event in flight may still add one result to the queue
  assign occupancy = {1'b0, q_count_i} + {{mctp_pkg::QCNT_W{1'b0}}, item_valid_r};
  assign in_chan.ready = (!item_valid_r || proc_en)
                         && (occupancy < (mctp_pkg::QCNT_W+1)'(mctp_pkg::QUEUE_DEPTH));
  assign accept    = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign now       = item_time_r;
  assign gap       = now - last_tick_r;
  assign since     = (last_pulse_r != '0) ? now - last_pulse_r : '0;
  assign tally_inc = tally_r + 16'd1;
  assign tsb_inc   = tsb_r + 8'd1;
  assign tsp_inc   = tsp_r + 8'd1;

  always_comb begin
    item_valid_nxt = accept ? 1'b1 : (proc_en ? 1'b0 : item_valid_r);
    silence_nxt    = silence_r;
    // a default beat write is ignored; beat length only takes its fixed reset value at reset
    if (cfg_chan.valid && cfg_chan.index == mctp_pkg::CFG_CLOCK_SILENCE) begin
      silence_nxt = cfg_chan.data;
    end
  end

  always_comb begin
    pulse_ticks_nxt = pulse_ticks_r;
    tsp_nxt         = tsp_r;
    tsb_nxt         = tsb_r;
    beat_length_nxt = beat_length_r;
    last_beat_nxt   = last_beat_r;
    last_clock_nxt  = last_clock_r;
    last_tick_nxt   = last_tick_r;
    last_pulse_nxt  = last_pulse_r;
    tally_nxt       = tally_r;
    gap_min_nxt     = gap_min_r;
    gap_max_nxt     = gap_max_r;
    running_nxt     = running_r;
    gmin            = gap_min_r;
    gmax            = gap_max_r;
    blen            = beat_length_r;
    param_change    = 1'b0;
    res_push        = 1'b0;
    res.free_run            = 1'b0;
    res.since_last_pulse_us = since;
    res.beat_interval_us    = beat_length_r;
    res.ticks_counted       = tally_r;
    res.min_gap_us          = gap_min_r;
    res.max_gap_us          = gap_max_r;
    if (proc_en) begin
      unique case (mctp_pkg::mode_t'(item_mode_r))
        mctp_pkg::MODE_TICK: begin
          last_clock_nxt = now;
          last_tick_nxt  = now;
          if (last_tick_r != '0) begin
            if (gap < gmin) gmin = gap;
            if (gap > gmax) gmax = gap;
          end
          tsb_nxt = tsb_inc;
          if (tsb_inc >= TPB) begin
            tsb_nxt       = '0;
            if (last_beat_r != '0) blen = now - last_beat_r;
            last_beat_nxt = now;
            param_change  = 1'b1;
          end
          beat_length_nxt = blen;
          res.beat_interval_us = blen;
          res.ticks_counted    = tally_inc;
          res.min_gap_us       = gmin;
          res.max_gap_us       = gmax;
          tsp_nxt = tsp_inc;
          if (tsp_inc >= pulse_ticks_r) begin
            // tick pulse reports then clears the statistics
            tsp_nxt        = '0;
            res_push       = 1'b1;
            last_pulse_nxt = now;
            tally_nxt      = '0;
            gap_min_nxt    = mctp_pkg::GAP_MIN_RESET;
            gap_max_nxt    = '0;
          end else begin
            tally_nxt   = tally_inc;
            gap_min_nxt = gmin;
            gap_max_nxt = gmax;
          end
        end
        mctp_pkg::MODE_START: begin
          tsb_nxt       = '0;
          tsp_nxt       = '0;
          last_beat_nxt = '0;
          last_tick_nxt = '0;
          tally_nxt     = '0;
          gap_min_nxt   = mctp_pkg::GAP_MIN_RESET;
          gap_max_nxt   = '0;
          running_nxt   = 1'b1;
        end
        mctp_pkg::MODE_CONTINUE: running_nxt = 1'b1;
        mctp_pkg::MODE_STOP:     running_nxt = 1'b0;
        mctp_pkg::MODE_IDLE_CHECK: begin
          if (running_r && (now - last_clock_r) >= silence_r
              && (now - last_pulse_r) >= interval_i) begin
            res_push       = 1'b1;
            res.free_run   = 1'b1;
            last_pulse_nxt = now;
          end
        end
        mctp_pkg::MODE_SET_DIV: begin
          if (item_ntp_r != '0) begin
            pulse_ticks_nxt = item_ntp_r;
            tsp_nxt         = '0;
            param_change    = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // hold events while the interval divide and multiply registers follow beat length or division
  always_comb begin
    if (param_change) begin
      hold_nxt = 2'd2;
    end else if (hold_r != '0) begin
      hold_nxt = hold_r - 2'd1;
    end else begin
      hold_nxt = hold_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r  <= 1'b0;
      silence_r     <= mctp_pkg::SILENCE_RESET;
      hold_r        <= 2'd2;
      pulse_ticks_r <= mctp_pkg::PULSE_TICKS_RST;
      tsp_r         <= '0;
      tsb_r         <= '0;
      beat_length_r <= mctp_pkg::BEAT_RESET;
      last_beat_r   <= '0;
      last_clock_r  <= '0;
      last_tick_r   <= '0;
      last_pulse_r  <= '0;
      tally_r       <= '0;
      gap_min_r     <= mctp_pkg::GAP_MIN_RESET;
      gap_max_r     <= '0;
      running_r     <= 1'b1;
    end else begin
      item_valid_r  <= item_valid_nxt;
      silence_r     <= silence_nxt;
      hold_r        <= hold_nxt;
      pulse_ticks_r <= pulse_ticks_nxt;
      tsp_r         <= tsp_nxt;
      tsb_r         <= tsb_nxt;
      beat_length_r <= beat_length_nxt;
      last_beat_r   <= last_beat_nxt;
      last_clock_r  <= last_clock_nxt;
      last_tick_r   <= last_tick_nxt;
      last_pulse_r  <= last_pulse_nxt;
      tally_r       <= tally_nxt;
      gap_min_r     <= gap_min_nxt;
      gap_max_r     <= gap_max_nxt;
      running_r     <= running_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode_r <= in_chan.mode;
      item_time_r <= in_chan.time_us;
      item_ntp_r  <= in_chan.new_ticks_per_pulse;
    end
  end

  assign beat_length_o         = beat_length_r;
  assign pulse_ticks_o         = pulse_ticks_r;
  assign res_push_o            = res_push;
  assign res_o                 = res;
  assign status_o.proc_en      = proc_en;
  assign status_o.hold_active  = (hold_r != '0);
  assign status_o.param_change = param_change;

endmodule

`default_nettype wire

FILE: hw/rtl/midi_clock_tempo_pulse_generator.sv
// top level of the midi clock tempo pulse generator
//
//   channel    dir  handshake     carries
//   in_chan    in   valid/ready   mode, time_us, new_ticks_per_pulse
//   out_chan   out  valid/ready   one pulse record per firing event
//   cfg_chan   in   valid/ready   register index and 32-bit data, always ready
//
// one event per cycle unless the input stalls; an event passes the event register,
// then its pulse the result queue; after a beat measurement or a division change
// the next event waits in the event register while the interval divide/multiply
// stages reload; synchronous reset; for the same reason an event taken right after
// reset waits in the event register until those stages have reloaded
// a four-entry result queue absorbs output stalls; input stalls once queued and pending results fill it
`default_nettype none

`include "midi_clock_tempo_pulse_generator_macros.svh"

module midi_clock_tempo_pulse_generator #(
  parameter int unsigned TICKS_PER_BEAT = mctp_pkg::TICKS_PER_BEAT_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mctp_in_if.sink    in_chan,
  mctp_out_if.source out_chan,
  mctp_cfg_if.sink   cfg_chan
);

  logic [31:0]                 interval;
  logic [31:0]                 beat_length;
  logic [7:0]                  pulse_ticks;
  logic [mctp_pkg::QCNT_W-1:0] q_count;
  logic                        res_push;
  mctp_pkg::result_t           res;
  mctp_pkg::core_status_t      status;
  logic                        reload_held;

  mctp_core #(
    .TICKS_PER_BEAT(TICKS_PER_BEAT)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .cfg_chan     (cfg_chan),
    .interval_i   (interval),
    .q_count_i    (q_count),
    .beat_length_o(beat_length),
    .pulse_ticks_o(pulse_ticks),
    .res_push_o   (res_push),
    .res_o        (res),
    .status_o     (status)
  );

  mctp_interval #(
    .TICKS_PER_BEAT(TICKS_PER_BEAT)
  ) u_interval (
    .clk          (clk),
    .beat_length_i(beat_length),
    .pulse_ticks_i(pulse_ticks),
    .interval_o   (interval)
  );

  mctp_out_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (res_push),
    .data_i  (res),
    .count_o (q_count),
    .out_chan(out_chan)
  );

  assign reload_held = status.hold_active && !status.proc_en;

  `MCTP_ASSERT_ALWAYS(a_queue_bound, q_count <= 3'd4, "result queue overflow")
  `MCTP_ASSERT_NEXT(a_push_visible, res_push, out_chan.valid, "pushed pulse not offered")
  `MCTP_ASSERT_NEXT(a_hold_after_change, status.param_change, reload_held, "reload not held")

endmodule

`default_nettype wire
